/* rtl/core/lbs_pkg.sv */
// Shared types and constants for the LED blink sequencer.
// Used by lbs_channel and led_blink_sequencer_core; depends on nothing.
`default_nettype none

package lbs_pkg;

   typedef enum logic [2:0] {
      CMD_TICK   = 3'd0,
      CMD_START  = 3'd1,
      CMD_STOP   = 3'd2,
      CMD_SET    = 3'd3,
      CMD_TOGGLE = 3'd4
   } lbs_cmd_type;

   localparam logic [9:0]  LBS_US_PER_MS     = 10'd1000;
   localparam logic [31:0] LBS_ENDLESS_COUNT = 32'hFFFF_FFFF;

   // Decoded request, as seen by one channel
   typedef struct packed {
      logic        enable;
      logic        tick;
      logic        start;
      logic        stop;
      logic        set_level;
      logic        toggle;
      logic        level;
      logic [31:0] on_us;
      logic [31:0] off_us;
      logic [31:0] count;
      logic [63:0] now_us;
   } lbs_ctl_type;

endpackage

`default_nettype wire

/* rtl/core/lbs_channel.sv */
// One LED channel: blink state, elapsed-time check and pin level.
// Depends on lbs_pkg for the decoded request struct.
`default_nettype none

module lbs_channel (
   input  logic                clock,
   input  logic                reset,
   input  lbs_pkg::lbs_ctl_type ctl,
   output logic                pin_in,
   output logic                active_in
);
   import lbs_pkg::*;

   logic        active_ff;
   logic [31:0] on_us_ff, on_us_in;
   logic [31:0] off_us_ff, off_us_in;
   logic        endless_ff, endless_in;
   logic [31:0] cycles_left_ff, cycles_left_in;
   logic        phase_on_ff, phase_on_in;
   logic [63:0] last_flip_ff, last_flip_in;
   logic        pin_ff;

   logic [63:0] elapsed;
   logic [31:0] need;
   logic        due;
   logic        last_cycle;

   assign elapsed    = ctl.now_us - last_flip_ff;
   assign need       = phase_on_ff ? on_us_ff : off_us_ff;
   assign due        = elapsed >= {32'd0, need};
   // a signed count of one or less ends the sequence
   assign last_cycle = (cycles_left_ff == 32'd0) || (cycles_left_ff == 32'd1)
                       || cycles_left_ff[31];

   always_comb begin
      active_in      = active_ff;
      on_us_in       = on_us_ff;
      off_us_in      = off_us_ff;
      endless_in     = endless_ff;
      cycles_left_in = cycles_left_ff;
      phase_on_in    = phase_on_ff;
      last_flip_in   = last_flip_ff;
      pin_in         = pin_ff;
      if (ctl.enable) begin
         if (ctl.tick) begin
            if (active_ff && due) begin
               last_flip_in = ctl.now_us;
               if (phase_on_ff) begin
                  phase_on_in = 1'b0;
                  pin_in      = 1'b0;
                  if (!endless_ff) begin
                     if (last_cycle) begin
                        cycles_left_in = 32'd0;
                        active_in      = 1'b0;
                     end else begin
                        cycles_left_in = cycles_left_ff - 32'd1;
                     end
                  end
               end else begin
                  phase_on_in = 1'b1;
                  pin_in      = 1'b1;
               end
            end
         end else if (ctl.start) begin
            active_in      = 1'b1;
            on_us_in       = ctl.on_us;
            off_us_in      = ctl.off_us;
            endless_in     = (ctl.count == LBS_ENDLESS_COUNT);
            cycles_left_in = ctl.count;
            phase_on_in    = 1'b1;
            last_flip_in   = ctl.now_us;
            pin_in         = 1'b1;
         end else if (ctl.stop) begin
            active_in = 1'b0;
         end else if (ctl.set_level) begin
            active_in = 1'b0;
            pin_in    = ctl.level;
         end else if (ctl.toggle) begin
            active_in = 1'b0;
            pin_in    = ~pin_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff      <= 1'b0;
         on_us_ff       <= 32'd0;
         off_us_ff      <= 32'd0;
         endless_ff     <= 1'b0;
         cycles_left_ff <= 32'd0;
         phase_on_ff    <= 1'b0;
         last_flip_ff   <= 64'd0;
         pin_ff         <= 1'b0;
      end else begin
         active_ff      <= active_in;
         on_us_ff       <= on_us_in;
         off_us_ff      <= off_us_in;
         endless_ff     <= endless_in;
         cycles_left_ff <= cycles_left_in;
         phase_on_ff    <= phase_on_in;
         last_flip_ff   <= last_flip_in;
         pin_ff         <= pin_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/led_blink_sequencer_core.sv */
// LED blink sequencer, top level: request register, decode, per-channel
// state and result register. Depends on lbs_pkg and lbs_channel.
//
// Takes one request per clock while results drain and returns exactly one
// result per request via the request register, then the result register.
// A new request is accepted while a result waits, as long as the request
// register is empty or can move on. The 23x10 bit ms-to-us scale and each
// channel's 64-bit elapsed-time compare sit between the request register
// and the result register; all channels are checked in parallel on a tick.
// Results report pin levels and blinking flags of channels 0 to 2.
`default_nettype none

module led_blink_sequencer_core #(
   parameter int CHANNELS = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_command,
   input  logic [1:0]  req_channel,
   input  logic        req_level,
   input  logic [22:0] req_on_time_ms,
   input  logic [22:0] req_off_time_ms,
   input  logic signed [31:0] req_cycle_count,
   input  logic [63:0] req_now_us,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_pin_levels,
   output logic [2:0]  rsp_blinking_mask
);
   import lbs_pkg::*;

   logic        s1_valid_ff;
   logic [2:0]  s1_command_ff;
   logic [1:0]  s1_channel_ff;
   logic        s1_level_ff;
   logic [22:0] s1_on_ms_ff;
   logic [22:0] s1_off_ms_ff;
   logic [31:0] s1_count_ff;
   logic [63:0] s1_now_ff;

   logic        rsp_valid_ff;
   logic [2:0]  rsp_pins_ff, rsp_pins_in;
   logic [2:0]  rsp_mask_ff, rsp_mask_in;

   logic        s1_go;
   logic        req_take;
   logic [32:0] on_prod, off_prod;
   logic [31:0] on_us, off_us;
   logic [CHANNELS-1:0] pin_next, active_next;

   // request register moves on when the result register is free or drains
   assign s1_go     = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_go;
   assign req_take  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_command_ff <= req_command;
         s1_channel_ff <= req_channel;
         s1_level_ff   <= req_level;
         s1_on_ms_ff   <= req_on_time_ms;
         s1_off_ms_ff  <= req_off_time_ms;
         s1_count_ff   <= req_cycle_count;
         s1_now_ff     <= req_now_us;
      end
   end

   // scale ms to us, saturate at 32 bits
   assign on_prod  = 33'(s1_on_ms_ff) * 33'(LBS_US_PER_MS);
   assign off_prod = 33'(s1_off_ms_ff) * 33'(LBS_US_PER_MS);
   assign on_us    = on_prod[32] ? 32'hFFFF_FFFF : on_prod[31:0];
   assign off_us   = off_prod[32] ? 32'hFFFF_FFFF : off_prod[31:0];

   genvar gi;
   generate
      for (gi = 0; gi < CHANNELS; gi++) begin : g_chan
         lbs_ctl_type ctl;
         logic        sel;

         assign sel           = (int'(s1_channel_ff) == gi);
         assign ctl.enable    = s1_go;
         assign ctl.tick      = (s1_command_ff == CMD_TICK);
         assign ctl.start     = sel && (s1_command_ff == CMD_START)
                                && (s1_count_ff != 32'd0);
         assign ctl.stop      = sel && (s1_command_ff == CMD_STOP);
         assign ctl.set_level = sel && (s1_command_ff == CMD_SET);
         assign ctl.toggle    = sel && (s1_command_ff == CMD_TOGGLE);
         assign ctl.level     = s1_level_ff;
         assign ctl.on_us     = on_us;
         assign ctl.off_us    = off_us;
         assign ctl.count     = s1_count_ff;
         assign ctl.now_us    = s1_now_ff;

         lbs_channel u_chan (
            .clock     (clock),
            .reset     (reset),
            .ctl       (ctl),
            .pin_in    (pin_next[gi]),
            .active_in (active_next[gi])
         );
      end

      for (gi = 0; gi < 3; gi++) begin : g_out
         if (gi < CHANNELS) begin : g_vis
            assign rsp_pins_in[gi] = pin_next[gi];
            assign rsp_mask_in[gi] = active_next[gi];
         end else begin : g_none
            assign rsp_pins_in[gi] = 1'b0;
            assign rsp_mask_in[gi] = 1'b0;
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         rsp_pins_ff <= rsp_pins_in;
         rsp_mask_ff <= rsp_mask_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pin_levels    = rsp_pins_ff;
   assign rsp_blinking_mask = rsp_mask_ff;

   a_ready_when_empty : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("request stalled while result register is empty");

   a_start_lights : assert property (@(posedge clock) disable iff (reset)
      s1_go && (s1_command_ff == CMD_START) && (s1_channel_ff == 2'd0)
      && (s1_count_ff != 32'd0) |=> rsp_pin_levels[0] && rsp_blinking_mask[0])
      else $error("start did not light and arm channel 0");

   a_stop_ends : assert property (@(posedge clock) disable iff (reset)
      s1_go && (s1_channel_ff == 2'd0) && ((s1_command_ff == CMD_STOP)
      || (s1_command_ff == CMD_SET) || (s1_command_ff == CMD_TOGGLE))
      |=> !rsp_blinking_mask[0])
      else $error("blinking not ended on channel 0");

   a_result_loaded : assert property (@(posedge clock) disable iff (reset)
      s1_go |=> rsp_valid)
      else $error("advanced request produced no result");

endmodule

`default_nettype wire

/* tb/led_blink_checker.sv */
// Scoreboard for the LED blink sequencer: tracks per-channel blink state from
// accepted requests and compares every accepted result in order.
// Depends on lbs_pkg.
`default_nettype none

module led_blink_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [2:0]         req_command,
   input  logic [1:0]         req_channel,
   input  logic               req_level,
   input  logic [22:0]        req_on_time_ms,
   input  logic [22:0]        req_off_time_ms,
   input  logic signed [31:0] req_cycle_count,
   input  logic [63:0]        req_now_us,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [2:0]         rsp_pin_levels,
   input  logic [2:0]         rsp_blinking_mask,
   output int                 mismatch_count,
   output int                 status_pending,
   output int                 status_checked
);
   import lbs_pkg::*;

   localparam int LED_COUNT = 3;

   typedef struct packed {
      logic [2:0] pins;
      logic [2:0] blinking;
   } led_status_type;

   led_status_type status_q[$];

   logic        blinking   [LED_COUNT];
   logic [31:0] on_us      [LED_COUNT];
   logic [31:0] off_us     [LED_COUNT];
   logic        endless    [LED_COUNT];
   logic [31:0] cycles_left[LED_COUNT];
   logic        lit_phase  [LED_COUNT];
   logic [63:0] last_flip  [LED_COUNT];
   logic        pin_on     [LED_COUNT];

   function automatic logic [31:0] scale_ms(input logic [22:0] ms);
      logic [33:0] us;
      us = ms * LBS_US_PER_MS;
      return (us > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : us[31:0];
   endfunction

   task automatic advance_channel(input int c, input logic [63:0] now);
      logic [31:0] wait_us;
      if (!blinking[c])
         return;
      wait_us = lit_phase[c] ? on_us[c] : off_us[c];
      // elapsed time wraps modulo 2^64
      if (now - last_flip[c] < {32'd0, wait_us})
         return;
      last_flip[c] = now;
      if (lit_phase[c]) begin
         lit_phase[c] = 1'b0;
         pin_on[c]    = 1'b0;
         if (!endless[c]) begin
            // a count of one or less, or negative, ends the sequence here
            if (cycles_left[c] <= 32'd1 || cycles_left[c][31]) begin
               cycles_left[c] = '0;
               blinking[c]    = 1'b0;
            end else begin
               cycles_left[c] = cycles_left[c] - 32'd1;
            end
         end
      end else begin
         lit_phase[c] = 1'b1;
         pin_on[c]    = 1'b1;
      end
   endtask

   task automatic apply_led_request(output led_status_type status);
      logic on_board;
      int   c;
      on_board = req_channel < LED_COUNT;
      c        = on_board ? int'(req_channel) : 0;
      case (req_command)
         CMD_TICK: begin
            for (int i = 0; i < LED_COUNT; i++)
               advance_channel(i, req_now_us);
         end
         CMD_START: begin
            if (on_board && req_cycle_count != 0) begin
               blinking[c]    = 1'b1;
               on_us[c]       = scale_ms(req_on_time_ms);
               off_us[c]      = scale_ms(req_off_time_ms);
               endless[c]     = (req_cycle_count == LBS_ENDLESS_COUNT);
               cycles_left[c] = req_cycle_count;
               lit_phase[c]   = 1'b1;
               last_flip[c]   = req_now_us;
               pin_on[c]      = 1'b1;
            end
         end
         CMD_STOP: begin
            if (on_board)
               blinking[c] = 1'b0;
         end
         CMD_SET: begin
            if (on_board) begin
               blinking[c] = 1'b0;
               pin_on[c]   = req_level;
            end
         end
         CMD_TOGGLE: begin
            if (on_board) begin
               blinking[c] = 1'b0;
               pin_on[c]   = !pin_on[c];
            end
         end
         default: ;
      endcase
      for (int i = 0; i < LED_COUNT; i++) begin
         status.pins[i]     = pin_on[i];
         status.blinking[i] = blinking[i];
      end
   endtask

   always @(posedge clock) begin
      led_status_type predicted;
      led_status_type oldest;
      if (reset) begin
         for (int i = 0; i < LED_COUNT; i++) begin
            blinking[i]    = 1'b0;
            on_us[i]       = '0;
            off_us[i]      = '0;
            endless[i]     = 1'b0;
            cycles_left[i] = '0;
            lit_phase[i]   = 1'b0;
            last_flip[i]   = '0;
            pin_on[i]      = 1'b0;
         end
         status_q.delete();
         mismatch_count = 0;
         status_checked = 0;
      end else begin
         // retire before predicting: a result never belongs to a same-edge request
         if (rsp_valid && rsp_ready) begin
            if (status_q.size() == 0) begin
               $display("%0t led_checker: unexpected result pins %b blinking %b",
                        $time, rsp_pin_levels, rsp_blinking_mask);
               mismatch_count++;
            end else begin
               oldest = status_q.pop_front();
               status_checked++;
               if (rsp_pin_levels !== oldest.pins) begin
                  $display("%0t led_checker: pin_levels expected %b actual %b",
                           $time, oldest.pins, rsp_pin_levels);
                  mismatch_count++;
               end
               if (rsp_blinking_mask !== oldest.blinking) begin
                  $display("%0t led_checker: blinking_mask expected %b actual %b",
                           $time, oldest.blinking, rsp_blinking_mask);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            apply_led_request(predicted);
            status_q.push_back(predicted);
         end
      end
      status_pending = status_q.size();
   end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Top of the LED blink sequencer bench: clock, reset, request and result
// stimulus with idling, and the verdict. Depends on lbs_pkg,
// led_blink_sequencer_core and led_blink_checker.
`default_nettype none

module tb_top;
   import lbs_pkg::*;

   localparam int RUN_LIMIT       = 400000;
   localparam int RANDOM_REQUESTS = 1000;
   localparam int DRAIN_CYCLES    = 8;

   typedef enum logic [1:0] {
      RSP_OPEN,
      RSP_SPOTTY,
      RSP_CHOKED
   } rsp_pace_type;

   logic               clock     = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [2:0]         req_command;
   logic [1:0]         req_channel;
   logic               req_level;
   logic [22:0]        req_on_time_ms;
   logic [22:0]        req_off_time_ms;
   logic signed [31:0] req_cycle_count;
   logic [63:0]        req_now_us;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [2:0]         rsp_pin_levels;
   logic [2:0]         rsp_blinking_mask;

   int           mismatch_count;
   int           status_pending;
   int           status_checked;
   int           cycle_no   = 0;
   int           burst_left = 0;
   int           pace_left  = 0;
   rsp_pace_type rsp_pace   = RSP_OPEN;
   logic [63:0]  sim_now;
   int           cmd_hits[8];
   logic         timed_out  = 1'b0;

   led_blink_sequencer_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_channel       (req_channel),
      .req_level         (req_level),
      .req_on_time_ms    (req_on_time_ms),
      .req_off_time_ms   (req_off_time_ms),
      .req_cycle_count   (req_cycle_count),
      .req_now_us        (req_now_us),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pin_levels    (rsp_pin_levels),
      .rsp_blinking_mask (rsp_blinking_mask)
   );

   led_blink_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_channel       (req_channel),
      .req_level         (req_level),
      .req_on_time_ms    (req_on_time_ms),
      .req_off_time_ms   (req_off_time_ms),
      .req_cycle_count   (req_cycle_count),
      .req_now_us        (req_now_us),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pin_levels    (rsp_pin_levels),
      .rsp_blinking_mask (rsp_blinking_mask),
      .mismatch_count    (mismatch_count),
      .status_pending    (status_pending),
      .status_checked    (status_checked)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_no <= cycle_no + 1;
   end

   // result side: switch between open, spotty and choked stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (pace_left == 0) begin
            rsp_pace  <= rsp_pace_type'($urandom_range(0, 2));
            pace_left <= $urandom_range(20, 150);
         end else begin
            pace_left <= pace_left - 1;
         end
         case (rsp_pace)
            RSP_OPEN:   rsp_ready <= 1'b1;
            RSP_SPOTTY: rsp_ready <= ($urandom_range(0, 3) != 0);
            default:    rsp_ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // send one request; open a new burst after a random gap when the last one ran out
   task automatic issue(input logic [2:0] cmd, input logic [1:0] ch, input logic lvl,
                        input logic [22:0] on_ms, input logic [22:0] off_ms,
                        input logic [31:0] count, input logic [63:0] now);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_channel     <= ch;
      req_level       <= lvl;
      req_on_time_ms  <= on_ms;
      req_off_time_ms <= off_ms;
      req_cycle_count <= count;
      req_now_us      <= now;
      cmd_hits[cmd]++;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   function automatic logic [22:0] random_ms();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick == 0)
         return 23'($urandom);
      if (pick == 1)
         return 23'($urandom_range(4294960, 4294975));
      return 23'($urandom_range(0, 4));
   endfunction

   task automatic send_random_request();
      logic [2:0]  cmd;
      logic [1:0]  ch;
      logic [31:0] count;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 50)      cmd = CMD_TICK;
      else if (pick < 72) cmd = CMD_START;
      else if (pick < 78) cmd = CMD_STOP;
      else if (pick < 84) cmd = CMD_SET;
      else if (pick < 96) cmd = CMD_TOGGLE;
      else                cmd = CMD_TOGGLE + 3'($urandom_range(1, 3));

      // mostly move forward, sometimes on whole-ms steps, jump back or wrap
      pick = $urandom_range(0, 99);
      if (pick < 2)
         sim_now = {$urandom, $urandom};
      else if (pick < 5)
         sim_now = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 6000));
      else if (pick < 8)
         sim_now = sim_now - 64'($urandom_range(0, 2000));
      else if (pick < 40)
         sim_now = sim_now + 64'(1000 * $urandom_range(0, 3));
      else
         sim_now = sim_now + 64'($urandom_range(0, 3000));

      ch = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));

      pick = $urandom_range(0, 99);
      if (pick < 60)      count = $urandom_range(1, 4);
      else if (pick < 74) count = LBS_ENDLESS_COUNT;
      else if (pick < 82) count = '0;
      else if (pick < 90) count = {1'b1, 31'($urandom)};
      else                count = $urandom;

      issue(cmd, ch, 1'($urandom), random_ms(), random_ms(), count, sim_now);
   endtask

   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_command     <= CMD_TICK;
      req_channel     <= '0;
      req_level       <= 1'b0;
      req_on_time_ms  <= '0;
      req_off_time_ms <= '0;
      req_cycle_count <= '0;
      req_now_us      <= '0;
      sim_now          = '0;
      foreach (cmd_hits[i]) cmd_hits[i] = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      fork
         begin
            // direct levels and toggles
            issue(CMD_SET,    2'd0, 1'b1, '0, '0, '0, 64'd0);
            issue(CMD_SET,    2'd1, 1'b0, '0, '0, '0, 64'd0);
            issue(CMD_TOGGLE, 2'd2, 1'b0, '0, '0, '0, 64'd0);
            issue(CMD_TOGGLE, 2'd2, 1'b0, '0, '0, '0, 64'd0);
            // two finite cycles, ticks on both sides of the first two boundaries
            issue(CMD_START,  2'd0, 1'b0, 23'd1, 23'd2, 32'd2, 64'd1000);
            issue(CMD_TICK,   2'd0, 1'b0, '0, '0, '0, 64'd1999);
            issue(CMD_TICK,   2'd0, 1'b0, '0, '0, '0, 64'd2000);
            issue(CMD_TICK,   2'd0, 1'b0, '0, '0, '0, 64'd3999);
            issue(CMD_TICK,   2'd0, 1'b0, '0, '0, '0, 64'd4000);
            issue(CMD_TICK,   2'd0, 1'b0, '0, '0, '0, 64'd5000);
            // zero count, saturated endless, negative count with zero durations
            issue(CMD_START,  2'd1, 1'b0, 23'd5, 23'd5, '0, 64'd5000);
            issue(CMD_START,  2'd1, 1'b1, '1, '1, LBS_ENDLESS_COUNT, 64'd5000);
            issue(CMD_START,  2'd2, 1'b0, '0, '0, 32'hFFFF_FFFB, 64'd6000);
            issue(CMD_TICK,   2'd3, 1'b1, '1, '1, '1, 64'd6000);
            issue(CMD_STOP,   2'd1, 1'b0, '0, '0, '0, 64'd6000);
            // channel off the board
            issue(CMD_START,  2'd3, 1'b0, 23'd1, 23'd1, 32'd3, 64'd7000);
            issue(CMD_SET,    2'd3, 1'b1, '0, '0, '0, 64'd7000);
            issue(CMD_TOGGLE, 2'd3, 1'b0, '0, '0, '0, 64'd7000);
            issue(CMD_STOP,   2'd3, 1'b0, '0, '0, '0, 64'd7000);
            // unused command codes
            issue(CMD_TOGGLE + 3'd1, 2'd0, 1'b1, '1, '1, '1, 64'd7000);
            issue(CMD_TOGGLE + 3'd3, 2'd2, 1'b0, '0, '0, '0, 64'd7000);
            // timestamp wrap
            issue(CMD_START,  2'd0, 1'b0, 23'd1, 23'd1, LBS_ENDLESS_COUNT,
                  64'hFFFF_FFFF_FFFF_FE0C);
            issue(CMD_TICK,   2'd0, 1'b0, '0, '0, '0, 64'd400);
            issue(CMD_TICK,   2'd0, 1'b0, '0, '0, '0, 64'd600);
            issue(CMD_TICK,   2'd0, 1'b0, '0, '0, '0, 64'd1600);

            sim_now = 64'd20000;
            repeat (RANDOM_REQUESTS) send_random_request();
            req_valid <= 1'b0;
            @(posedge clock);
            wait (status_pending == 0);
            repeat (DRAIN_CYCLES) @(posedge clock);
         end
         begin
            wait (cycle_no >= RUN_LIMIT);
            timed_out = 1'b1;
         end
      join_any

      $display("tb: %0d ticks, %0d starts, %0d stops, %0d set-level, %0d toggles sent",
               cmd_hits[CMD_TICK], cmd_hits[CMD_START], cmd_hits[CMD_STOP],
               cmd_hits[CMD_SET], cmd_hits[CMD_TOGGLE]);
      $display("tb: %0d unused codes sent, %0d results compared, %0d mismatches",
               cmd_hits[5] + cmd_hits[6] + cmd_hits[7], status_checked, mismatch_count);
      if (timed_out) begin
         $display("tb: failure");
      end else if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* led_blink_sequencer_core.f */
rtl/core/lbs_pkg.sv
rtl/core/lbs_channel.sv
rtl/core/led_blink_sequencer_core.sv
tb/led_blink_checker.sv
tb/tb_top.sv
